@@ hw/rtl/ipcfifo_pkg.sv @@
// shared types and constants of the interprocessor mailbox fifo
`timescale 1ns / 1ps

package ipcfifo_pkg;

  // send fifo depth per processor
  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // request codes
  localparam logic [2:0] REQ_SYNC_RD = 3'd0;
  localparam logic [2:0] REQ_SYNC_WR = 3'd1;
  localparam logic [2:0] REQ_CTRL_RD = 3'd2;
  localparam logic [2:0] REQ_CTRL_WR = 3'd3;
  localparam logic [2:0] REQ_SEND    = 3'd4;

  // send access sizes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  // send status codes
  localparam logic [1:0] SEND_OK       = 2'd0;
  localparam logic [1:0] SEND_DISABLED = 2'd1;
  localparam logic [1:0] SEND_FULL     = 2'd2;

  // register bit positions
  localparam int SYNC_IRQ_REQ_BIT = 5;
  localparam int SYNC_IRQ_EN_BIT  = 6;
  localparam int CTRL_IRQ_EN_BIT  = 2;
  localparam int CTRL_CLEAR_BIT   = 3;
  localparam int CTRL_ERR_BIT     = 6;
  localparam int CTRL_ENABLE_BIT  = 7;

  // one register access beat
  typedef struct packed {
    logic [2:0]  req_type;
    logic        requester;
    logic        byte_offset;
    logic [1:0]  access_size;
    logic [31:0] write_data;
  } in_item_t;

  // one result beat
  typedef struct packed {
    logic [7:0] read_data;
    logic       sync_irq_raise;
    logic       sync_irq_target;
    logic [1:0] send_status;
  } out_item_t;

endpackage

@@ hw/rtl/dual_core_ipc_sync_fifo.sv @@
// top level of the interprocessor mailbox, sending side
//
// Each beat on the input channel is one register access by one processor:
// sync read or write, fifo control read or write, or a send fifo write.
// A beat is taken at a clock edge with start high and busy low. The access
// is held in an input register, decoded and applied to the mailbox state
// in the next cycle, and its result is put in the output register.
// The result shows on out_valid/out_item once the beat has passed the input
// and output registers, for exactly one cycle.
// Throughput: one access per cycle while busy is low; each access touches
// only a few flags and at most one send fifo slot, all settled in the decode cycle.
// Reset (rst_n low, synchronous) clears every flag, count and pointer and
// holds busy high until the first clock edge with rst_n high; fifo slot contents
// are not cleared and are valid only once written.
// The receiver cannot stall: each result must be taken in the cycle it is
// shown.
`timescale 1ns / 1ps

module dual_core_ipc_sync_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  ipcfifo_pkg::in_item_t  in_item,
  output logic                   out_valid,
  output ipcfifo_pkg::out_item_t out_item
);

  logic                  stg_vld;
  ipcfifo_pkg::in_item_t stg_item;

  // input register
  ipcfifo_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .stg_vld  (stg_vld),
    .stg_item (stg_item)
  );

  // decode, state and result register
  ipcfifo_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .stg_vld   (stg_vld),
    .stg_item  (stg_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

@@ hw/rtl/ipcfifo_in_stage.sv @@
// input register of the mailbox: captures one access beat per cycle while busy is low
`timescale 1ns / 1ps

module ipcfifo_in_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  ipcfifo_pkg::in_item_t in_item,
  output logic                  stg_vld,
  output ipcfifo_pkg::in_item_t stg_item
);

  logic                  busy_r;
  logic                  vld_r;
  ipcfifo_pkg::in_item_t item_r;
  logic                  accept;

  assign accept = start && !busy_r;

  // busy only while coming out of reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= 1'b0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= accept;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign busy     = busy_r;
  assign stg_vld  = vld_r;
  assign stg_item = item_r;

endmodule

@@ hw/rtl/ipcfifo_core.sv @@
// mailbox state, send fifo storage and result register
`timescale 1ns / 1ps

module ipcfifo_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   stg_vld,
  input  ipcfifo_pkg::in_item_t  stg_item,
  output logic                   out_valid,
  output ipcfifo_pkg::out_item_t out_item
);

  localparam int CW = ipcfifo_pkg::CNT_W;
  localparam int PW = ipcfifo_pkg::PTR_W;

  // per-processor state
  logic [3:0]    nib_r     [2];
  logic [3:0]    nib_nxt   [2];
  logic [1:0]    rie_r, rie_nxt;
  logic [CW-1:0] cnt_r     [2];
  logic [CW-1:0] cnt_nxt   [2];
  logic [PW-1:0] wptr_r    [2];
  logic [PW-1:0] wptr_nxt  [2];
  logic [1:0]    sie_r, sie_nxt;
  logic [1:0]    cie_r, cie_nxt;
  logic [1:0]    err_r, err_nxt;
  logic [1:0]    ena_r, ena_nxt;

  // send fifo storage
  logic [31:0] send_mem_r [2][ipcfifo_pkg::FIFO_DEPTH];

  logic                   out_vld_r;
  ipcfifo_pkg::out_item_t res_r, res_nxt;

  logic          self_id, peer_id;
  logic [7:0]    b;
  logic [31:0]   word;
  logic [1:0]    empty, full;
  logic          wr_en;
  logic [PW:0]   wr_addr;

  assign self_id = stg_item.requester;
  assign peer_id = ~stg_item.requester;
  assign b       = stg_item.write_data[7:0];

  // empty and full flags of both fifos
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      empty[i] = (cnt_r[i] == '0);
      full[i]  = (cnt_r[i] >= CW'(ipcfifo_pkg::FIFO_DEPTH));
    end
  end

  // send word replication
  always_comb begin
    unique case (stg_item.access_size)
      ipcfifo_pkg::SIZE_BYTE: word = {4{b}};
      ipcfifo_pkg::SIZE_HALF: word = {2{stg_item.write_data[15:0]}};
      default:                word = stg_item.write_data;
    endcase
  end

  // request decode and state update
  always_comb begin
    nib_nxt  = nib_r;
    rie_nxt  = rie_r;
    cnt_nxt  = cnt_r;
    wptr_nxt = wptr_r;
    sie_nxt  = sie_r;
    cie_nxt  = cie_r;
    err_nxt  = err_r;
    ena_nxt  = ena_r;
    res_nxt  = '0;
    wr_en    = 1'b0;
    wr_addr  = {self_id, wptr_r[self_id]};
    if (stg_vld) begin
      unique case (stg_item.req_type)
        ipcfifo_pkg::REQ_SYNC_RD: begin
          if (!stg_item.byte_offset) begin
            res_nxt.read_data = {4'd0, nib_r[peer_id]};
          end else begin
            res_nxt.read_data = {1'b0, rie_r[self_id], 2'd0, nib_r[self_id]};
          end
        end
        ipcfifo_pkg::REQ_SYNC_WR: begin
          if (stg_item.byte_offset) begin
            nib_nxt[self_id] = b[3:0];
            rie_nxt[self_id] = b[ipcfifo_pkg::SYNC_IRQ_EN_BIT];
            if (b[ipcfifo_pkg::SYNC_IRQ_REQ_BIT] && rie_r[peer_id]) begin
              res_nxt.sync_irq_raise  = 1'b1;
              res_nxt.sync_irq_target = peer_id;
            end
          end
        end
        ipcfifo_pkg::REQ_CTRL_RD: begin
          if (!stg_item.byte_offset) begin
            res_nxt.read_data = {5'd0, sie_r[self_id], full[self_id], empty[self_id]};
          end else begin
            res_nxt.read_data = {ena_r[self_id], err_r[self_id], 3'd0, cie_r[self_id],
                                 full[peer_id], empty[peer_id]};
          end
        end
        ipcfifo_pkg::REQ_CTRL_WR: begin
          if (!stg_item.byte_offset) begin
            sie_nxt[self_id] = b[ipcfifo_pkg::CTRL_IRQ_EN_BIT];
            if (b[ipcfifo_pkg::CTRL_CLEAR_BIT]) begin
              cnt_nxt[self_id]  = '0;
              wptr_nxt[self_id] = '0;
            end
          end else begin
            cie_nxt[self_id] = b[ipcfifo_pkg::CTRL_IRQ_EN_BIT];
            if (b[ipcfifo_pkg::CTRL_ERR_BIT]) begin
              err_nxt[self_id] = 1'b0;
            end
            ena_nxt[self_id] = b[ipcfifo_pkg::CTRL_ENABLE_BIT];
          end
        end
        ipcfifo_pkg::REQ_SEND: begin
          if (!ena_r[self_id]) begin
            res_nxt.send_status = ipcfifo_pkg::SEND_DISABLED;
          end else if (full[self_id]) begin
            err_nxt[self_id]    = 1'b1;
            res_nxt.send_status = ipcfifo_pkg::SEND_FULL;
          end else begin
            wr_en            = 1'b1;
            cnt_nxt[self_id] = cnt_r[self_id] + CW'(1);
            if (wptr_r[self_id] == PW'(ipcfifo_pkg::FIFO_DEPTH - 1)) begin
              wptr_nxt[self_id] = '0;
            end else begin
              wptr_nxt[self_id] = wptr_r[self_id] + PW'(1);
            end
          end
        end
        default: begin
          res_nxt = '0;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        nib_r[i]  <= '0;
        cnt_r[i]  <= '0;
        wptr_r[i] <= '0;
      end
      rie_r     <= '0;
      sie_r     <= '0;
      cie_r     <= '0;
      err_r     <= '0;
      ena_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      nib_r     <= nib_nxt;
      cnt_r     <= cnt_nxt;
      wptr_r    <= wptr_nxt;
      rie_r     <= rie_nxt;
      sie_r     <= sie_nxt;
      cie_r     <= cie_nxt;
      err_r     <= err_nxt;
      ena_r     <= ena_nxt;
      out_vld_r <= stg_vld;
    end
  end

  // result payload and fifo slot write
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (wr_en) begin
      send_mem_r[wr_addr[PW]][wr_addr[PW-1:0]] <= word;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = res_r;

endmodule

@@ hw/rtl/ipcfifo_chk.sv @@
// port-level checker of the mailbox, bound to the top level
`timescale 1ns / 1ps

module ipcfifo_chk (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input ipcfifo_pkg::in_item_t  in_item,
  input logic                   out_valid,
  input ipcfifo_pkg::out_item_t out_item
);

  // every accepted beat gives a result after the input and output registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##2 out_valid)
    else $error("accepted beat without result");

  // no result without a matching accepted beat
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without accepted beat");

  // a sync interrupt comes only from a sync write and always goes to the partner of the requester
  a_irq_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.sync_irq_raise |->
      out_item.sync_irq_target == !$past(in_item.requester, 2)
      && $past(in_item.req_type, 2) == ipcfifo_pkg::REQ_SYNC_WR)
    else $error("sync interrupt to wrong target");

  // send status only for send beats
  a_send_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.send_status != ipcfifo_pkg::SEND_OK |->
      $past(in_item.req_type, 2) == ipcfifo_pkg::REQ_SEND)
    else $error("send status on non-send beat");

  // read data only for read beats
  a_read_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.read_data != 8'd0 |->
      ($past(in_item.req_type, 2) == ipcfifo_pkg::REQ_SYNC_RD
       || $past(in_item.req_type, 2) == ipcfifo_pkg::REQ_CTRL_RD))
    else $error("read data on non-read beat");

endmodule

bind dual_core_ipc_sync_fifo ipcfifo_chk u_ipcfifo_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
